FILE: src/bpd_pkg.sv
// shared types, operation codes and status codes of the bounded position deque
package bpd_pkg;

	localparam int CAPACITY_DEFAULT = 256;

	localparam int OP_W     = 3;
	localparam int COORD_W  = 16;
	localparam int SYM_W    = 8;
	localparam int INDEX_W  = 8;
	localparam int SIZE_W   = 9;
	localparam int STATUS_W = 2;

	typedef logic [OP_W-1:0]           op_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SYM_W-1:0]          sym_t;
	typedef logic [INDEX_W-1:0]        index_t;
	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic [STATUS_W-1:0]       status_t;

	localparam op_t OP_INS_HEAD = 3'd0;
	localparam op_t OP_INS_TAIL = 3'd1;
	localparam op_t OP_REM_HEAD = 3'd2;
	localparam op_t OP_REM_TAIL = 3'd3;
	localparam op_t OP_RD_HEAD  = 3'd4;
	localparam op_t OP_RD_TAIL  = 3'd5;
	localparam op_t OP_RD_INDEX = 3'd6;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// one stored record, 40 bits
	typedef struct packed {
		coord_t x;
		coord_t y;
		sym_t   symbol;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// what the output stage needs to know about an issued beat
	typedef struct packed {
		logic    is_read;
		status_t status;
		size_t   size;
	} beat_info_t;

endpackage

FILE: src/bpd_if.sv
// request and response channel interfaces of the bounded position deque
interface bpd_in_if;
	logic              valid;
	logic              ready;
	bpd_pkg::op_t      operation;
	bpd_pkg::coord_t   pos_x;
	bpd_pkg::coord_t   pos_y;
	bpd_pkg::sym_t     pos_symbol;
	bpd_pkg::index_t   read_index;

	modport source (output valid, output operation, output pos_x, output pos_y,
		output pos_symbol, output read_index, input ready);
	modport sink (input valid, input operation, input pos_x, input pos_y,
		input pos_symbol, input read_index, output ready);
endinterface

interface bpd_out_if;
	logic              valid;
	logic              ready;
	bpd_pkg::coord_t   out_x;
	bpd_pkg::coord_t   out_y;
	bpd_pkg::sym_t     out_symbol;
	bpd_pkg::size_t    list_size;
	bpd_pkg::status_t  status;

	modport source (output valid, output out_x, output out_y, output out_symbol,
		output list_size, output status, input ready);
	modport sink (input valid, input out_x, input out_y, input out_symbol,
		input list_size, input status, output ready);
endinterface

FILE: src/bpd_store.sv
// ring record memory, one write or one registered read per cycle
module bpd_store #(
	parameter int DEPTH = bpd_pkg::CAPACITY_DEFAULT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  bpd_pkg::rec_t wdata,
	output bpd_pkg::rec_t rdata
);
	import bpd_pkg::*;

	rec_t mem [DEPTH];
	rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/bpd_ctrl.sv
// head pointer and count, operation decode and ring address generation
module bpd_ctrl #(
	parameter int CAPACITY = bpd_pkg::CAPACITY_DEFAULT,
	parameter int PW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  bpd_pkg::op_t        operation,
	input  bpd_pkg::rec_t       rec,
	input  bpd_pkg::index_t     read_index,
	output logic                mem_we,
	output logic                mem_re,
	output logic [PW-1:0]       mem_addr,
	output bpd_pkg::rec_t       mem_wdata,
	output bpd_pkg::beat_info_t info
);
	import bpd_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;

	logic [PW-1:0] head_q, head_n, head_dec, slot;
	logic [CW-1:0] count_q, count_n;
	logic [SW-1:0] offset, slot_sum;
	logic          full, empty, idx_valid, do_we, do_re;
	status_t       status;

	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign idx_valid = (SW'(read_index) < SW'(count_q));
	assign head_dec  = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - PW'(1);

	// offset from head, shared ring adder with one wrap correction
	always_comb begin
		case (operation)
			OP_INS_TAIL: offset = SW'(count_q);
			OP_REM_HEAD: offset = SW'(1);
			OP_RD_TAIL:  offset = SW'(count_q - CW'(1));
			OP_RD_INDEX: offset = SW'(read_index);
			default:     offset = '0;
		endcase
	end

	assign slot_sum = SW'(head_q) + offset;
	assign slot = (slot_sum >= SW'(CAPACITY)) ? PW'(slot_sum - SW'(CAPACITY)) : PW'(slot_sum);

	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		do_we    = 1'b0;
		do_re    = 1'b0;
		mem_addr = slot;
		status   = ST_OK;
		unique case (operation) inside
			OP_INS_HEAD: begin
				mem_addr = head_dec;
				if (full) begin
					status = ST_FULL;
				end else begin
					do_we   = 1'b1;
					head_n  = head_dec;
					count_n = count_q + CW'(1);
				end
			end
			OP_INS_TAIL: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_we   = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			OP_REM_HEAD: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					head_n  = slot;
					count_n = count_q - CW'(1);
				end
			end
			OP_REM_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_n = count_q - CW'(1);
				end
			end
			OP_RD_HEAD, OP_RD_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					do_re = 1'b1;
				end
			end
			OP_RD_INDEX: begin
				if (!idx_valid) begin
					status = ST_EMPTY;
				end else begin
					do_re = 1'b1;
				end
			end
			default: begin
				status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

	assign mem_we       = accept && do_we;
	assign mem_re       = accept && do_re;
	assign mem_wdata    = rec;
	assign info.is_read = do_re;
	assign info.status  = status;
	assign info.size    = SIZE_W'(count_n);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(head_q) < SW'(CAPACITY))
		else $error("head pointer outside ring");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q) && $stable(head_q))
		else $error("pointer state changed without a beat");

endmodule

FILE: src/bounded_position_deque_core.sv
// top level of the bounded position deque: decode, ring memory and output register
// a request beat is registered into stage 1 together with its memory read, then into the output register
// throughput: one request beat per cycle, requests stall once a held response fills stage 1
// reset clears the head pointer, the entry count and both valid flags at once;
// the record memory is not cleared, only entries inside the count are ever read
module bounded_position_deque_core #(
	parameter int CAPACITY = bpd_pkg::CAPACITY_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	bpd_in_if.sink   req,
	bpd_out_if.source rsp
);
	import bpd_pkg::*;

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// request beat taken this cycle
	logic       accept;
	// memory request from the decoder
	logic       mem_we, mem_re;
	logic [PW-1:0] mem_addr;
	rec_t       mem_wdata, mem_rdata, in_rec;
	beat_info_t info;

	// stage 1: issued beat, held beside its registered memory read data
	logic       valid_s1;
	beat_info_t info_s1;
	logic       adv_s1;

	// output register
	logic       rsp_valid_q;
	rec_t       rsp_rec_q;
	size_t      rsp_size_q;
	status_t    rsp_status_q;

	assign in_rec.x      = req.pos_x;
	assign in_rec.y      = req.pos_y;
	assign in_rec.symbol = req.pos_symbol;

	// stage 1 moves on when the output register is empty or being drained
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	bpd_ctrl #(
		.CAPACITY (CAPACITY),
		.PW       (PW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (req.operation),
		.rec        (in_rec),
		.read_index (req.read_index),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.info       (info)
	);

	// a write at one edge is visible to a read issued at the next,
	// so back-to-back beats on the same entry need no forwarding
	bpd_store #(
		.DEPTH (CAPACITY),
		.AW    (PW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// read data register holds while stage 1 stalls, since no new read is issued then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// non-read beats and refused reads carry zero data
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_rec_q    <= info_s1.is_read ? mem_rdata : '0;
			rsp_size_q   <= info_s1.size;
			rsp_status_q <= info_s1.status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_x      = rsp_rec_q.x;
	assign rsp.out_y      = rsp_rec_q.y;
	assign rsp.out_symbol = rsp_rec_q.symbol;
	assign rsp.list_size  = rsp_size_q;
	assign rsp.status     = rsp_status_q;

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp.ready |-> !req.ready)
		else $error("request taken while pipeline is full");

	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != ST_OK |-> rsp_rec_q == '0)
		else $error("refused beat carries data");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_valid_q)
		else $error("stage 1 beat lost on its way out");

endmodule
